>>> hw/rtl/first_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_macros
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants and result codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FFHA_HEAP_BYTES   = 4096;
  localparam int FFHA_HDR_BYTES    = 16;
  localparam int FFHA_ALIGN_BYTES  = 4;

  // request size with header fits in this many bits
  localparam int FFHA_NEED_W       = 14;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FAIL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

endpackage

>>> hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// Each store access runs through issue, RAM read, then write-back.
// Allocate: a read of each free-list entry visited, then up to 18 accesses for
// split, merge and relinking; a zero size or misaligned free answers with no access.
// Free: up to 23 accesses. One transaction is in flight at a time.
// After reset a clearing pass over every store word holds in_tready low.
`include "first_fit_heap_allocator_macros.svh"
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with boundary-tag coalescing over a word-indexed store.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = FFHA_HEAP_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[12:0], release_offset[24:13]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_offset[11:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int AW    = $clog2(WORDS);
  localparam int PW    = AW + 1;
  localparam int LW    = $clog2(HEAP_BYTES + 1);
  localparam int NW    = FFHA_NEED_W;
  localparam int CW    = (LW > NW) ? LW : NW;
  localparam int XW    = ((AW > 10) ? AW : 10) + 1;
  localparam logic [PW-1:0] NIL     = PW'(WORDS);
  localparam logic [AW-1:0] END_BLK = AW'(WORDS - FFHA_HDR_BYTES / 4);

  typedef struct packed {
    logic [LW-1:0] len;
    logic [AW-1:0] prev;
    logic          used;
    logic          hdr;
    logic [PW-1:0] fnext;
    logic [PW-1:0] fprev;
  } rec_t;

  localparam int RW = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DEC, ST_RD, ST_WR, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_READ, OP_SET_PREV, OP_SET_LEN, OP_ADD_LEN, OP_SET_FNEXT, OP_SET_FPREV,
    OP_SET_LINKS, OP_SET_USED, OP_CLR_USED, OP_WRITE
  } op_t;

  typedef enum logic [4:0] {
    PH_A_WALK, PH_A_CHECK, PH_A_SETC, PH_A_NX, PH_A_NXCHK, PH_A_ABS, PH_A_PUSH,
    PH_A_UNC, PH_A_MARK, PH_A_DONE,
    PH_F_CHK, PH_F_P, PH_F_RB, PH_F_NX, PH_F_NCHK, PH_F_ABS, PH_F_END,
    PH_F_FREE, PH_F_PUSH, PH_F_DONE,
    PH_U0, PH_U1, PH_U2, PH_U3, PH_P0, PH_P1, PH_P2, PH_B0, PH_B1, PH_B2, PH_B3
  } ph_t;

  state_t        state_r, state_nxt;
  ph_t           phase_r, phase_nxt;
  ph_t           ret_r, ret_nxt;
  op_t           op_r, op_nxt;
  logic [AW-1:0] op_addr_r, op_addr_nxt;
  rec_t          op_val_r, op_val_nxt;
  rec_t          rec_r, rec_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic [AW-1:0] rest_r, rest_nxt;
  logic [LW-1:0] rlen_r, rlen_nxt;
  logic [AW-1:0] nx_r, nx_nxt;
  logic [AW-1:0] blk_r, blk_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          back_r, back_nxt;
  logic [AW-1:0] sa_r, sa_nxt;
  logic [AW-1:0] sb_r, sb_nxt;
  logic [AW-1:0] tn_r, tn_nxt;
  logic [PW-1:0] ln_r, ln_nxt;
  logic [PW-1:0] lp_r, lp_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [11:0]   res_off_r, res_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [11:0]   out_off_r, out_off_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;
  logic [RW-1:0] mem_rdata_raw;

  ffha_ram #(.DW(RW), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (op_addr_r),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = rec_t'(mem_rdata_raw);

  function automatic logic [AW-1:0] follow(input logic [AW-1:0] idx,
                                           input logic [LW-1:0] len);
    logic [PW-1:0] sum;
    sum = PW'(idx) + PW'(len >> 2);
    return (sum >= PW'(WORDS)) ? END_BLK : sum[AW-1:0];
  endfunction

  // write port: clearing pass or the modify half of an access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_addr_r;
    mem_wdata = mem_rdata;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '{len: '0, prev: '0, used: 1'b0, hdr: 1'b0, fnext: NIL, fprev: NIL};
      if (clr_r == '0) begin
        mem_wdata.len  = LW'(HEAP_BYTES - FFHA_HDR_BYTES);
        mem_wdata.prev = END_BLK;
        mem_wdata.hdr  = 1'b1;
      end else if (clr_r == END_BLK) begin
        mem_wdata.len  = LW'(FFHA_HDR_BYTES);
        mem_wdata.used = 1'b1;
        mem_wdata.hdr  = 1'b1;
      end
    end else if (state_r == ST_WR) begin
      mem_we = (op_r != OP_READ);
      case (op_r)
        OP_SET_PREV:  mem_wdata.prev  = op_val_r.prev;
        OP_SET_LEN:   mem_wdata.len   = op_val_r.len;
        OP_ADD_LEN:   mem_wdata.len   = mem_rdata.len + op_val_r.len;
        OP_SET_FNEXT: mem_wdata.fnext = op_val_r.fnext;
        OP_SET_FPREV: mem_wdata.fprev = op_val_r.fprev;
        OP_SET_LINKS: begin
          mem_wdata.fnext = op_val_r.fnext;
          mem_wdata.fprev = op_val_r.fprev;
        end
        OP_SET_USED:  mem_wdata.used  = 1'b1;
        OP_CLR_USED:  mem_wdata.used  = 1'b0;
        OP_WRITE:     mem_wdata       = op_val_r;
        default:      mem_wdata       = mem_rdata;
      endcase
    end
  end

  always_comb begin
    logic          issue;
    op_t           iop;
    logic [AW-1:0] iaddr;
    rec_t          ival;
    logic          fin;
    logic [1:0]    fst;
    logic [11:0]   foff;
    logic [11:0]   off;
    logic [9:0]    k10;
    logic [AW-1:0] tmp;

    issue = 1'b0;
    iop   = OP_READ;
    iaddr = '0;
    ival  = '{len: '0, prev: '0, used: 1'b0, hdr: 1'b0, fnext: NIL, fprev: NIL};
    fin   = 1'b0;
    fst   = STATUS_OK;
    foff  = '0;
    off   = in_tdata[24:13];
    k10   = 10'((off - 12'(FFHA_HDR_BYTES)) >> 2);
    tmp   = '0;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ret_nxt       = ret_r;
    op_nxt        = op_r;
    op_addr_nxt   = op_addr_r;
    op_val_nxt    = op_val_r;
    rec_nxt       = rec_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    need_nxt      = need_r;
    rest_nxt      = rest_r;
    rlen_nxt      = rlen_r;
    nx_nxt        = nx_r;
    blk_nxt       = blk_r;
    k_nxt         = k_r;
    back_nxt      = back_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    tn_nxt        = tn_r;
    ln_nxt        = ln_r;
    lp_nxt        = lp_r;
    res_st_nxt    = res_st_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_off_nxt   = out_off_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == 1'b0) begin
            if (in_tdata[12:0] == '0) begin
              fin = 1'b1;
              fst = STATUS_FAIL;
            end else begin
              need_nxt = (NW'(in_tdata[12:0]) + NW'(FFHA_HDR_BYTES + FFHA_ALIGN_BYTES - 1))
                         & ~NW'(FFHA_ALIGN_BYTES - 1);
              cur_nxt   = head_r;
              phase_nxt = PH_A_WALK;
              state_nxt = ST_DEC;
            end
          end else begin
            if (off[1:0] != 2'b00 || off < 12'(FFHA_HDR_BYTES) ||
                XW'(k10) >= XW'(END_BLK)) begin
              fin = 1'b1;
              fst = STATUS_INVALID;
            end else begin
              tmp   = AW'(k10);
              k_nxt = tmp;
              issue = 1'b1;
              iaddr = tmp;
              phase_nxt = PH_F_CHK;
            end
          end
        end
      end
      ST_DEC: begin
        case (phase_r)
          PH_A_WALK: begin
            if (cur_r == NIL) begin
              fin = 1'b1;
              fst = STATUS_FAIL;
            end else begin
              issue = 1'b1;
              iaddr = cur_r[AW-1:0];
              phase_nxt = PH_A_CHECK;
            end
          end
          PH_A_CHECK: begin
            if (CW'(rec_r.len) >= CW'(need_r)) begin
              if (CW'(need_r) + CW'(FFHA_HDR_BYTES + FFHA_ALIGN_BYTES) <= CW'(rec_r.len)) begin
                tmp      = cur_r[AW-1:0] + AW'(need_r >> 2);
                rest_nxt = tmp;
                rlen_nxt = rec_r.len - LW'(need_r);
                issue    = 1'b1;
                iop      = OP_WRITE;
                iaddr    = tmp;
                ival.len  = rec_r.len - LW'(need_r);
                ival.prev = cur_r[AW-1:0];
                ival.hdr  = 1'b1;
                phase_nxt = PH_A_SETC;
              end else begin
                sa_nxt    = cur_r[AW-1:0];
                ret_nxt   = PH_A_MARK;
                phase_nxt = PH_U0;
              end
            end else begin
              cur_nxt   = rec_r.fnext;
              phase_nxt = PH_A_WALK;
            end
          end
          PH_A_SETC: begin
            issue    = 1'b1;
            iop      = OP_SET_LEN;
            iaddr    = cur_r[AW-1:0];
            ival.len = LW'(need_r);
            phase_nxt = PH_A_NX;
          end
          PH_A_NX: begin
            tmp       = follow(rest_r, rlen_r);
            nx_nxt    = tmp;
            issue     = 1'b1;
            iop       = OP_SET_PREV;
            iaddr     = tmp;
            ival.prev = rest_r;
            phase_nxt = PH_A_NXCHK;
          end
          PH_A_NXCHK: begin
            if (!rec_r.used) begin
              sa_nxt  = nx_r;
              ret_nxt = PH_A_ABS;
              phase_nxt = PH_U0;
            end else begin
              sa_nxt  = rest_r;
              ret_nxt = PH_A_UNC;
              phase_nxt = PH_P0;
            end
          end
          PH_A_ABS: begin
            sa_nxt    = rest_r;
            sb_nxt    = nx_r;
            ret_nxt   = PH_A_PUSH;
            phase_nxt = PH_B0;
          end
          PH_A_PUSH: begin
            sa_nxt    = rest_r;
            ret_nxt   = PH_A_UNC;
            phase_nxt = PH_P0;
          end
          PH_A_UNC: begin
            sa_nxt    = cur_r[AW-1:0];
            ret_nxt   = PH_A_MARK;
            phase_nxt = PH_U0;
          end
          PH_A_MARK: begin
            issue = 1'b1;
            iop   = OP_SET_USED;
            iaddr = cur_r[AW-1:0];
            phase_nxt = PH_A_DONE;
          end
          PH_A_DONE: begin
            fin  = 1'b1;
            fst  = STATUS_OK;
            foff = 12'((32'(cur_r[AW-1:0]) << 2) + 32'(FFHA_HDR_BYTES));
          end
          PH_F_CHK: begin
            if (!rec_r.hdr || !rec_r.used) begin
              fin = 1'b1;
              fst = STATUS_INVALID;
            end else begin
              blk_nxt = rec_r.prev;
              issue   = 1'b1;
              iaddr   = rec_r.prev;
              phase_nxt = PH_F_P;
            end
          end
          PH_F_P: begin
            if (!rec_r.used) begin
              back_nxt  = 1'b1;
              sa_nxt    = blk_r;
              sb_nxt    = k_r;
              ret_nxt   = PH_F_RB;
              phase_nxt = PH_B0;
            end else begin
              back_nxt  = 1'b0;
              blk_nxt   = k_r;
              phase_nxt = PH_F_RB;
            end
          end
          PH_F_RB: begin
            issue = 1'b1;
            iaddr = blk_r;
            phase_nxt = PH_F_NX;
          end
          PH_F_NX: begin
            tmp    = follow(blk_r, rec_r.len);
            nx_nxt = tmp;
            issue  = 1'b1;
            iaddr  = tmp;
            phase_nxt = PH_F_NCHK;
          end
          PH_F_NCHK: begin
            if (!rec_r.used) begin
              sa_nxt    = nx_r;
              ret_nxt   = PH_F_ABS;
              phase_nxt = PH_U0;
            end else begin
              phase_nxt = PH_F_END;
            end
          end
          PH_F_ABS: begin
            sa_nxt    = blk_r;
            sb_nxt    = nx_r;
            ret_nxt   = PH_F_END;
            phase_nxt = PH_B0;
          end
          PH_F_END: begin
            if (back_r) begin
              sa_nxt    = blk_r;
              ret_nxt   = PH_F_FREE;
              phase_nxt = PH_U0;
            end else begin
              phase_nxt = PH_F_FREE;
            end
          end
          PH_F_FREE: begin
            issue = 1'b1;
            iop   = OP_CLR_USED;
            iaddr = blk_r;
            phase_nxt = PH_F_PUSH;
          end
          PH_F_PUSH: begin
            sa_nxt    = blk_r;
            ret_nxt   = PH_F_DONE;
            phase_nxt = PH_P0;
          end
          PH_F_DONE: begin
            fin = 1'b1;
            fst = STATUS_OK;
          end
          // unlink sa from the free list
          PH_U0: begin
            issue = 1'b1;
            iaddr = sa_r;
            phase_nxt = PH_U1;
          end
          PH_U1: begin
            ln_nxt = rec_r.fnext;
            lp_nxt = rec_r.fprev;
            if (rec_r.fprev < NIL) begin
              issue      = 1'b1;
              iop        = OP_SET_FNEXT;
              iaddr      = rec_r.fprev[AW-1:0];
              ival.fnext = rec_r.fnext;
            end else begin
              head_nxt = rec_r.fnext;
            end
            phase_nxt = PH_U2;
          end
          PH_U2: begin
            if (ln_r < NIL) begin
              issue      = 1'b1;
              iop        = OP_SET_FPREV;
              iaddr      = ln_r[AW-1:0];
              ival.fprev = lp_r;
            end
            phase_nxt = PH_U3;
          end
          PH_U3: begin
            issue = 1'b1;
            iop   = OP_SET_LINKS;
            iaddr = sa_r;
            phase_nxt = ret_r;
          end
          // push sa on the list front
          PH_P0: begin
            issue      = 1'b1;
            iop        = OP_SET_LINKS;
            iaddr      = sa_r;
            ival.fnext = head_r;
            phase_nxt  = PH_P1;
          end
          PH_P1: begin
            if (head_r < NIL) begin
              issue      = 1'b1;
              iop        = OP_SET_FPREV;
              iaddr      = head_r[AW-1:0];
              ival.fprev = PW'(sa_r);
            end
            phase_nxt = PH_P2;
          end
          PH_P2: begin
            head_nxt  = PW'(sa_r);
            phase_nxt = ret_r;
          end
          // fold successor sb into sa
          PH_B0: begin
            issue = 1'b1;
            iaddr = sb_r;
            phase_nxt = PH_B1;
          end
          PH_B1: begin
            tn_nxt   = follow(sb_r, rec_r.len);
            issue    = 1'b1;
            iop      = OP_ADD_LEN;
            iaddr    = sa_r;
            ival.len = rec_r.len;
            phase_nxt = PH_B2;
          end
          PH_B2: begin
            issue     = 1'b1;
            iop       = OP_SET_PREV;
            iaddr     = tn_r;
            ival.prev = sa_r;
            phase_nxt = PH_B3;
          end
          PH_B3: begin
            issue = 1'b1;
            iop   = OP_WRITE;
            iaddr = sb_r;
            phase_nxt = ret_r;
          end
          default: begin
            fin = 1'b1;
            fst = STATUS_FAIL;
          end
        endcase
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        rec_nxt   = mem_rdata;
        state_nxt = ST_DEC;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_off_nxt   = res_off_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (issue) begin
      op_nxt      = iop;
      op_addr_nxt = iaddr;
      op_val_nxt  = ival;
      state_nxt   = ST_RD;
    end
    if (fin) begin
      res_st_nxt  = fst;
      res_off_nxt = foff;
      state_nxt   = ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_A_WALK;
      ret_r       <= PH_A_WALK;
      op_r        <= OP_READ;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      ret_r       <= ret_nxt;
      op_r        <= op_nxt;
    end
    op_addr_r <= op_addr_nxt;
    op_val_r  <= op_val_nxt;
    rec_r     <= rec_nxt;
    cur_r     <= cur_nxt;
    need_r    <= need_nxt;
    rest_r    <= rest_nxt;
    rlen_r    <= rlen_nxt;
    nx_r      <= nx_nxt;
    blk_r     <= blk_nxt;
    k_r       <= k_nxt;
    back_r    <= back_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    tn_r      <= tn_nxt;
    ln_r      <= ln_nxt;
    lp_r      <= lp_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    out_st_r  <= out_st_nxt;
    out_off_r <= out_off_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_off_r};
  assign out_tuser  = out_st_r;

  `FFHA_ASSERT_IMP(a_fail_no_offset, out_tvalid && out_tuser != STATUS_OK, out_tdata == '0,
    "failed or invalid result carries an offset")
  `FFHA_ASSERT_IMP(a_head_not_marker, state_r != ST_CLEAR, head_r != PW'(END_BLK),
    "free list head points at end marker")
  `FFHA_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "accepted a transaction while still busy")
  `FFHA_ASSERT_IMP(a_no_write_on_read, state_r == ST_WR && op_r == OP_READ, !mem_we,
    "plain read wrote the store")

endmodule
